>>> rtl/core/isc_pkg.sv
// Package for the image signature classifier: sizes, format codes and the
// per-blob state record shared by the top level and the rule matcher.
// No dependencies.
package isc_pkg;

	localparam int HEADER_BYTES  = 12;
	localparam int TAIL_BYTES    = 18;
	localparam int SEARCH_WINDOW = 1000;

	localparam int HEAD_W  = HEADER_BYTES * 8;
	localparam int TAIL_W  = TAIL_BYTES * 8;
	localparam int COUNT_W = 11;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	typedef enum logic [4:0] {
		FMT_JPG  = 5'd0,
		FMT_PNG  = 5'd1,
		FMT_GIF  = 5'd2,
		FMT_WEBP = 5'd3,
		FMT_BMP  = 5'd4,
		FMT_TIFF = 5'd5,
		FMT_AVIF = 5'd6,
		FMT_HEIC = 5'd7,
		FMT_ICO  = 5'd8,
		FMT_CUR  = 5'd9,
		FMT_PSD  = 5'd10,
		FMT_XCF  = 5'd11,
		FMT_EXR  = 5'd12,
		FMT_HDR  = 5'd13,
		FMT_JP2  = 5'd14,
		FMT_J2K  = 5'd15,
		FMT_JXL  = 5'd16,
		FMT_JXR  = 5'd17,
		FMT_TGA  = 5'd18,
		FMT_PCX  = 5'd19,
		FMT_SVG  = 5'd20,
		FMT_PBM  = 5'd21,
		FMT_PGM  = 5'd22,
		FMT_PPM  = 5'd23,
		FMT_PAM  = 5'd24,
		FMT_XBM  = 5'd25,
		FMT_XPM  = 5'd26,
		FMT_FITS = 5'd27,
		FMT_FLIF = 5'd28,
		FMT_QOI  = 5'd29,
		FMT_WBMP = 5'd30
	} fmt_t;

	// head: byte 0 in the top bits; tail: oldest byte in the top bits
	typedef struct packed {
		logic [HEAD_W-1:0]  head;
		logic [TAIL_W-1:0]  tail;
		logic [COUNT_W-1:0] count;
		logic               svg_seen;
	} blob_state_t;

endpackage

>>> rtl/core/isc_classify.sv
// Signature rule matcher: priority chain of header, footer and size tests.
// Depends on isc_pkg.
module isc_classify (
	input  isc_pkg::blob_state_t st,
	output isc_pkg::fmt_t        code
);

	localparam int HW = isc_pkg::HEAD_W;

	logic [7:0]                 d0, d1, d2, d3;
	logic [isc_pkg::COUNT_W-1:0] n;
	logic                       heic_brand;
	logic [31:0]                brand;

	assign n  = st.count;
	assign d0 = st.head[HW-1 -: 8];
	assign d1 = st.head[HW-9 -: 8];
	assign d2 = st.head[HW-17 -: 8];
	assign d3 = st.head[HW-25 -: 8];
	assign brand = st.head[HW-65 -: 32];

	assign heic_brand = (brand == "heic") || (brand == "heix") || (brand == "hevc") ||
		(brand == "hevx") || (brand == "heim") || (brand == "heis") ||
		(brand == "hevm") || (brand == "hevs") || (brand == "mif1") ||
		(brand == "msf1");

	always_comb begin
		code = isc_pkg::FMT_JPG;
		if (n < 11'd4) begin
			code = isc_pkg::FMT_JPG;
		end else if (d0 == 8'hFF && d1 == 8'hD8 && d2 == 8'hFF) begin
			code = isc_pkg::FMT_JPG;
		end else if (n >= 11'd8 && st.head[HW-1 -: 64] == 64'h89504E470D0A1A0A) begin
			code = isc_pkg::FMT_PNG;
		end else if (n >= 11'd6 && (st.head[HW-1 -: 48] == "GIF87a" ||
				st.head[HW-1 -: 48] == "GIF89a")) begin
			code = isc_pkg::FMT_GIF;
		end else if (n >= 11'd12 && st.head[HW-1 -: 32] == "RIFF" &&
				st.head[HW-65 -: 32] == "WEBP") begin
			code = isc_pkg::FMT_WEBP;
		end else if (d0 == 8'h42 && d1 == 8'h4D) begin
			code = isc_pkg::FMT_BMP;
		end else if (st.head[HW-1 -: 32] == 32'h49492A00 ||
				st.head[HW-1 -: 32] == 32'h4D4D002A) begin
			code = isc_pkg::FMT_TIFF;
		end else if (n >= 11'd12 && st.head[HW-33 -: 64] == "ftypavif") begin
			code = isc_pkg::FMT_AVIF;
		end else if (n >= 11'd12 && st.head[HW-33 -: 32] == "ftyp" && heic_brand) begin
			code = isc_pkg::FMT_HEIC;
		end else if (d0 == 8'h00 && d1 == 8'h00 && d2 == 8'h01 && d3 == 8'h00) begin
			code = isc_pkg::FMT_ICO;
		end else if (d0 == 8'h00 && d1 == 8'h00 && d2 == 8'h02 && d3 == 8'h00) begin
			code = isc_pkg::FMT_CUR;
		end else if (st.head[HW-1 -: 32] == "8BPS") begin
			code = isc_pkg::FMT_PSD;
		end else if (n >= 11'd9 && st.head[HW-1 -: 72] == 72'h67696D7020786366_20) begin
			code = isc_pkg::FMT_XCF;
		end else if (st.head[HW-1 -: 32] == 32'h762F3101) begin
			code = isc_pkg::FMT_EXR;
		end else if (n >= 11'd10 && (st.head[HW-1 -: 80] == "#?RADIANCE" ||
				st.head[HW-1 -: 48] == "#?RGBE")) begin
			code = isc_pkg::FMT_HDR;
		end else if (n >= 11'd8 && st.head[HW-1 -: 64] == 64'h0000000C6A502020) begin
			code = isc_pkg::FMT_JP2;
		end else if (st.head[HW-1 -: 32] == 32'hFF4FFF51) begin
			code = isc_pkg::FMT_J2K;
		end else if (d0 == 8'hFF && d1 == 8'h0A) begin
			code = isc_pkg::FMT_JXL;
		end else if (n >= 11'd12 &&
				st.head[HW-1 -: 96] == 96'h0000000C4A584C200D0A870A) begin
			code = isc_pkg::FMT_JXL;
		end else if (((d0 == 8'h49 && d1 == 8'h49) || (d0 == 8'h4D && d1 == 8'h4D)) &&
				d2 == 8'hBC && (d3 == 8'h00 || d3 == 8'h01)) begin
			code = isc_pkg::FMT_JXR;
		end else if (n >= 11'd26 &&
				st.tail == 144'h54525545564953494F4E2D5846494C452E00) begin
			code = isc_pkg::FMT_TGA;
		end else if (n >= 11'd18 && d1 <= 8'd1 &&
				(d2 inside {8'd1, 8'd2, 8'd3, 8'd9, 8'd10, 8'd11})) begin
			code = isc_pkg::FMT_TGA;
		end else if (d0 == 8'h0A && d2 == 8'h01) begin
			code = isc_pkg::FMT_PCX;
		end else if (n >= 11'd5 && st.svg_seen && (st.head[HW-1 -: 40] == "<?xml" ||
				st.head[HW-1 -: 32] == "<svg")) begin
			code = isc_pkg::FMT_SVG;
		end else if (d0 == "P" && (d1 inside {"1", "2", "3", "4", "5", "6", "7"})) begin
			case (d1)
				"1", "4": code = isc_pkg::FMT_PBM;
				"2", "5": code = isc_pkg::FMT_PGM;
				"3", "6": code = isc_pkg::FMT_PPM;
				default:  code = isc_pkg::FMT_PAM;
			endcase
		end else if (n >= 11'd7 && st.head[HW-1 -: 56] == "#define") begin
			code = isc_pkg::FMT_XBM;
		end else if (n >= 11'd9 && st.head[HW-1 -: 72] == "/* XPM */") begin
			code = isc_pkg::FMT_XPM;
		end else if (n >= 11'd6 && st.head[HW-1 -: 48] == "SIMPLE") begin
			code = isc_pkg::FMT_FITS;
		end else if (st.head[HW-1 -: 32] == "FLIF") begin
			code = isc_pkg::FMT_FLIF;
		end else if (st.head[HW-1 -: 32] == "qoif") begin
			code = isc_pkg::FMT_QOI;
		end else if (d0 == 8'h00 && d1 == 8'h00) begin
			code = isc_pkg::FMT_WBMP;
		end
	end

endmodule

>>> rtl/core/image_signature_classifier.sv
// Top level of the image signature classifier: blob state registers,
// rule matcher instance and a two-entry output register with skid.
// Depends on isc_pkg and isc_classify.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------
//  in      | to block  | in_valid/in_stall  | data_byte, last_byte
//  out     | from block| out_valid/out_stall| format_code
//
// One byte is taken per cycle while in_stall is low; the code for a blob is
// registered from the single matcher pass when its final byte is accepted.
// Reset clears all blob state and empties the output register and skid.
// in_stall rises only when both the output register and the skid entry hold
// undelivered codes, i.e. after a blob finishes while out_stall holds another.
module image_signature_classifier (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [4:0] format_code
);

	localparam int HW = isc_pkg::HEAD_W;
	localparam int TW = isc_pkg::TAIL_W;

	isc_pkg::blob_state_t st_q, st_next;
	isc_pkg::fmt_t        res_code;
	isc_pkg::fmt_t        out_code_q, skid_code_q;
	logic                 out_valid_q, skid_valid_q;
	logic                 in_fire, res_valid, out_fire;

	assign in_stall  = skid_valid_q;
	assign in_fire   = in_valid && !in_stall;
	assign res_valid = in_fire && last_byte;
	assign out_valid = out_valid_q;
	assign out_fire  = out_valid_q && !out_stall;
	assign format_code = out_code_q;

	// state as it stands once the incoming byte is folded in
	always_comb begin
		st_next = st_q;
		for (int i = 0; i < isc_pkg::HEADER_BYTES; i++) begin
			if (st_q.count == isc_pkg::COUNT_W'(i))
				st_next.head[HW-1-8*i -: 8] = data_byte;
		end
		if (st_q.count >= isc_pkg::COUNT_W'(3) &&
				st_q.count < isc_pkg::COUNT_W'(isc_pkg::SEARCH_WINDOW) &&
				st_q.tail[23:0] == "<sv" && data_byte == "g")
			st_next.svg_seen = 1'b1;
		st_next.tail = {st_q.tail[TW-9:0], data_byte};
		if (st_q.count != isc_pkg::COUNT_MAX)
			st_next.count = st_q.count + 1'b1;
	end

	isc_classify u_classify (
		.st   (st_next),
		.code (res_code)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (in_fire) begin
			if (last_byte)
				st_q <= '0;
			else
				st_q <= st_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || out_fire) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= res_valid;
			end
		end else if (res_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_fire) begin
			if (skid_valid_q)
				out_code_q <= skid_code_q;
			else if (res_valid)
				out_code_q <= res_code;
		end else if (res_valid) begin
			skid_code_q <= res_code;
		end
	end

`ifndef SYNTHESIS
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held with output register empty");

	a_result_follows_final: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |=> out_valid_q)
		else $error("final byte accepted but no code presented");

	a_state_clears: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |=> (st_q.count == '0 && !st_q.svg_seen))
		else $error("blob state not cleared after final byte");

	a_svg_needs_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.svg_seen |-> (st_q.count >= isc_pkg::COUNT_W'(4)))
		else $error("svg tag flagged before four bytes were seen");
`endif

endmodule
